// ----- rtl/uv_sensor_index_alarm_macros.svh -----
// Assertion helpers shared by the block's modules.
// Each macro samples on the rising edge of clock and is disabled in reset.
`ifndef UV_SENSOR_INDEX_ALARM_MACROS_SVH
`define UV_SENSOR_INDEX_ALARM_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define UVSIA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define UVSIA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/uvsia_pkg.sv -----
package uvsia_pkg;

   // Field widths.
   localparam int ADC_W      = 16;
   localparam int SAMPLE_W   = 12;
   localparam int SUM_W      = 14;
   localparam int IDX_W      = 4;
   localparam int IRR_W      = 13;
   localparam int BP_W       = 9;
   localparam int SCALED_W   = 23;
   localparam int COUNT_W    = 14;
   localparam int LEVEL_W    = 4;
   localparam int MINUTES_W  = 8;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 8;

   // Arithmetic constants.
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
   localparam int                  NUM_POINTS = 13;
   localparam int                  BP_SHIFT   = 12;
   localparam logic [10:0]         MV_SCALE   = 11'd1200;
   localparam logic [5:0]          SECS_PER_MIN = 6'd60;

   // Division by three as a multiply by ceil(2^16 / 3) and a shift; exact for
   // every sum of three clamped samples.
   localparam int                  DIV3_SHIFT = 16;
   localparam int                  DIV3_MUL_W = 15;
   localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 15'd21846;
   localparam int                  PROD_W     = SUM_W + DIV3_MUL_W;

   localparam int REPORT_PERIOD_DEF = 5;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WARN_ENABLE   = 8'd0,
      CSR_WARN_LEVEL    = 8'd1,
      CSR_WARN_MINUTES  = 8'd2,
      CSR_NOTIFY_ENABLE = 8'd3
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCALE,
      ST_LAUNCH,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // Control and status of the breakpoint search unit.
   typedef struct packed {
      logic                start;
      logic [SCALED_W-1:0] scaled;
   } srch_ctrl_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [IDX_W-1:0] idx;
   } srch_stat_type;

   // Millivolt breakpoints.
   function automatic logic [BP_W-1:0] bp_mv(input logic [IDX_W-1:0] i);
      logic [BP_W-1:0] v;
      unique case (i)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd10;
         4'd2:    v = 9'd90;
         4'd3:    v = 9'd129;
         4'd4:    v = 9'd161;
         4'd5:    v = 9'd198;
         4'd6:    v = 9'd235;
         4'd7:    v = 9'd279;
         4'd8:    v = 9'd296;
         4'd9:    v = 9'd326;
         4'd10:   v = 9'd398;
         4'd11:   v = 9'd437;
         4'd12:   v = 9'd489;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // Irradiance in thousandths for each UV index.
   function automatic logic [IRR_W-1:0] irr_rom(input logic [IDX_W-1:0] i);
      logic [IRR_W-1:0] v;
      unique case (i)
         4'd0:    v = 13'd0;
         4'd1:    v = 13'd1550;
         4'd2:    v = 13'd2312;
         4'd3:    v = 13'd2750;
         4'd4:    v = 13'd3312;
         4'd5:    v = 13'd3500;
         4'd6:    v = 13'd3857;
         4'd7:    v = 13'd4214;
         4'd8:    v = 13'd4475;
         4'd9:    v = 13'd4704;
         4'd10:   v = 13'd4903;
         4'd11:   v = 13'd5125;
         4'd12:   v = 13'd5250;
         default: v = 13'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/uvsia_req_if.sv -----
interface uvsia_req_if;
   import uvsia_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ADC_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

// ----- rtl/uvsia_rsp_if.sv -----
interface uvsia_rsp_if;
   import uvsia_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] averaged_sample;
   logic [IDX_W-1:0]    uv_index;
   logic [IRR_W-1:0]    irradiance_milli;
   logic                alarm;
   logic                report_due;

   modport source (output valid, output averaged_sample, output uv_index,
                   output irradiance_milli, output alarm, output report_due,
                   input ready);
   modport sink   (input valid, input averaged_sample, input uv_index,
                   input irradiance_milli, input alarm, input report_due,
                   output ready);
endinterface

// ----- rtl/uvsia_csr_if.sv -----
interface uvsia_csr_if;
   import uvsia_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/uvsia_search.sv -----
module uvsia_search (
   input  logic                    clock,
   input  logic                    reset,
   input  uvsia_pkg::srch_ctrl_type ctrl,
   output uvsia_pkg::srch_stat_type stat
);
   import uvsia_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SCALED_W-1:0] best_ff, best_in;
   logic [SCALED_W-1:0] scaled_ff, scaled_in;
   logic [SCALED_W-1:0] ref_mv;
   logic [SCALED_W-1:0] gap;
   logic                closer;

   // One breakpoint per cycle through an absolute difference and compare.
   always_comb begin
      ref_mv = SCALED_W'(bp_mv(step_ff)) << BP_SHIFT;
      gap    = (scaled_ff >= ref_mv) ? (scaled_ff - ref_mv) : (ref_mv - scaled_ff);
      closer = (step_ff == '0) || (gap < best_ff);
   end

   // Step sequencing; a strict compare keeps the lower index on a tie.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      idx_in    = idx_ff;
      best_in   = best_ff;
      scaled_in = scaled_ff;
      if (ctrl.start) begin
         busy_in   = 1'b1;
         step_in   = '0;
         scaled_in = ctrl.scaled;
      end else if (busy_ff) begin
         if (closer) begin
            idx_in  = step_ff;
            best_in = gap;
         end
         if (step_ff == IDX_W'(NUM_POINTS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff   <= best_in;
      scaled_ff <= scaled_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.idx  = idx_ff;

endmodule

// ----- rtl/uv_sensor_index_alarm.sv -----
// An accepted item passes the division, scaling, launch, search and finish states;
// the breakpoint search compares one of the 13 breakpoints per cycle. No new item
// is taken until the last result is loaded into the output register; the next
// item is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears history, counters, the output valid
// and restores the register defaults; no clearing pass is needed.
`include "uv_sensor_index_alarm_macros.svh"

module uv_sensor_index_alarm #(
   parameter int REPORT_PERIOD = uvsia_pkg::REPORT_PERIOD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   uvsia_req_if.sink   req_if,
   uvsia_rsp_if.source rsp_if,
   uvsia_csr_if.sink   csr_if
);
   import uvsia_pkg::*;

   localparam int PHASE_W = (REPORT_PERIOD > 1) ? $clog2(REPORT_PERIOD) : 1;
   localparam logic [PHASE_W:0] PERIOD_END = (PHASE_W + 1)'(REPORT_PERIOD);

   state_type state_ff, state_in;

   // Configuration registers.
   logic                 warn_enable_ff;
   logic [LEVEL_W-1:0]   warn_level_ff;
   logic [MINUTES_W-1:0] warn_minutes_ff;
   logic                 notify_enable_ff;

   // Sample path.
   logic [SAMPLE_W-1:0] hist0_ff, hist1_ff;
   logic [SAMPLE_W-1:0] clamped;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PROD_W-1:0]   div_prod;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [SCALED_W-1:0] scaled_ff, scaled_in;

   // Alarm and report state.
   logic [COUNT_W-1:0] danger_ff, danger_in;
   logic [COUNT_W-1:0] danger_inc;
   logic [COUNT_W-1:0] danger_limit;
   logic               over_level;
   logic               alarm_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PHASE_W:0]   phase_inc;
   logic               due_in;

   // Output register.
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_avg_ff;
   logic [IDX_W-1:0]    rsp_idx_ff;
   logic [IRR_W-1:0]    rsp_irr_ff;
   logic                rsp_alarm_ff;
   logic                rsp_due_ff;
   logic                out_free;

   // Sequencer outputs.
   logic req_ready;
   logic load_sample;
   logic load_avg;
   logic load_scaled;
   logic load_result;

   srch_ctrl_type srch_ctrl;
   srch_stat_type srch_stat;

   uvsia_search u_search (
      .clock (clock),
      .reset (reset),
      .ctrl  (srch_ctrl),
      .stat  (srch_stat)
   );

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_if.valid) state_in = ST_DIV;
         ST_DIV:    state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_SEARCH;
         ST_SEARCH: if (srch_stat.done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready        = 1'b0;
      load_sample      = 1'b0;
      load_avg         = 1'b0;
      load_scaled      = 1'b0;
      load_result      = 1'b0;
      srch_ctrl.start  = 1'b0;
      srch_ctrl.scaled = scaled_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            load_sample = req_if.valid;
         end
         ST_DIV:    load_avg        = 1'b1;
         ST_SCALE:  load_scaled     = 1'b1;
         ST_LAUNCH: srch_ctrl.start = 1'b1;
         ST_SEARCH: ;
         ST_FINISH: load_result     = out_free;
         default: ;
      endcase
   end

   assign req_if.ready     = req_ready;
   assign csr_if.ready     = 1'b1;

   // Clamp the raw sample and form the three-sample sum.
   always_comb begin
      if (req_if.adc_sample < 0) begin
         clamped = '0;
      end else if (req_if.adc_sample > $signed({4'b0, SAMPLE_MAX})) begin
         clamped = SAMPLE_MAX;
      end else begin
         clamped = req_if.adc_sample[SAMPLE_W-1:0];
      end
      sum_in = SUM_W'(hist0_ff) + SUM_W'(hist1_ff) + SUM_W'(clamped);
   end

   // Truncated division by three, then the millivolt scaling.
   always_comb begin
      div_prod  = PROD_W'(sum_ff) * PROD_W'(DIV3_MUL);
      avg_in    = div_prod[DIV3_SHIFT +: SAMPLE_W];
      scaled_in = SCALED_W'(avg_ff) * SCALED_W'(MV_SCALE);
   end

   // Sustained over-threshold counter and report phase.
   always_comb begin
      danger_inc   = danger_ff + COUNT_W'(1);
      danger_limit = COUNT_W'(warn_minutes_ff) * COUNT_W'(SECS_PER_MIN);
      over_level   = warn_enable_ff && (srch_stat.idx > warn_level_ff);
      alarm_in     = 1'b0;
      if (!over_level) begin
         danger_in = '0;
      end else if (danger_inc > danger_limit) begin
         danger_in = '0;
         alarm_in  = 1'b1;
      end else begin
         danger_in = danger_inc;
      end
      phase_inc = (PHASE_W + 1)'(phase_ff) + (PHASE_W + 1)'(1);
      if (phase_inc >= (PHASE_W + 1)'(REPORT_PERIOD)) begin
         phase_in = '0;
      end else begin
         phase_in = phase_inc[PHASE_W-1:0];
      end
      due_in = notify_enable_ff && (phase_in == '0);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         warn_enable_ff   <= 1'b0;
         warn_level_ff    <= 4'd2;
         warn_minutes_ff  <= 8'd2;
         notify_enable_ff <= 1'b0;
         hist0_ff         <= '0;
         hist1_ff         <= '0;
         danger_ff        <= '0;
         phase_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_if.valid) begin
            unique case (csr_index_type'(csr_if.index))
               CSR_WARN_ENABLE:   warn_enable_ff   <= csr_if.data[0];
               CSR_WARN_LEVEL:    warn_level_ff    <= csr_if.data[LEVEL_W-1:0];
               CSR_WARN_MINUTES:  warn_minutes_ff  <= csr_if.data[MINUTES_W-1:0];
               CSR_NOTIFY_ENABLE: notify_enable_ff <= csr_if.data[0];
               default: ;
            endcase
         end
         if (load_sample) begin
            hist0_ff <= hist1_ff;
            hist1_ff <= clamped;
         end
         if (load_result) begin
            danger_ff    <= danger_in;
            phase_ff     <= phase_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load_sample) sum_ff    <= sum_in;
      if (load_avg)    avg_ff    <= avg_in;
      if (load_scaled) scaled_ff <= scaled_in;
      if (load_result) begin
         rsp_avg_ff   <= avg_ff;
         rsp_idx_ff   <= srch_stat.idx;
         rsp_irr_ff   <= irr_rom(srch_stat.idx);
         rsp_alarm_ff <= alarm_in;
         rsp_due_ff   <= due_in;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.averaged_sample  = rsp_avg_ff;
   assign rsp_if.uv_index         = rsp_idx_ff;
   assign rsp_if.irradiance_milli = rsp_irr_ff;
   assign rsp_if.alarm            = rsp_alarm_ff;
   assign rsp_if.report_due       = rsp_due_ff;

   // Checks on the sequencer and the counters.
   `UVSIA_ASSERT_SAME(a_done_in_search, srch_stat.done, state_ff == ST_SEARCH, "stray done")
   `UVSIA_ASSERT_SAME(a_alarm_needs_level, load_result && alarm_in, over_level, "stray alarm")
   `UVSIA_ASSERT_NEXT(a_finish_shows_item, load_result, rsp_valid_ff, "result not shown")
   `UVSIA_ASSERT_SAME(a_phase_range, 1'b1, {1'b0, phase_ff} < PERIOD_END, "bad phase")
   `UVSIA_ASSERT_SAME(a_launch_when_idle, state_ff == ST_LAUNCH, !srch_stat.busy, "search busy")

endmodule
